// ===== hw/rtl/amlk_pkg.sv =====
// shared types, constants and keypad decode function for the adc moving average keypad unit
// no dependencies; imported by every module of the block
`default_nettype none

package amlk_pkg;

   // fixed field geometry
   localparam int SAMPLE_W   = 12;
   localparam int KEY_W      = 4;
   localparam int NUM_FIELDS = 8;

   // filter geometry
   localparam int WINDOW   = 3;
   localparam int CHANNELS = 8;

   localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W     = $clog2(WINDOW + 1);
   localparam int WIN_DEPTH = CHANNELS * WINDOW;
   localparam int WADDR_W   = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
   localparam int SUM_W     = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);

   // divide by WINDOW as multiply by reciprocal, exact for any sum below 2**SUM_W
   localparam int RECIP_SHIFT = SUM_W + 5;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SHIFT) / WINDOW + 1);

   // keypad ladder
   localparam int LADDER_SCALE  = 120;
   localparam int LADDER_FULL   = 4096;
   localparam int LADDER_P_W    = $clog2(LADDER_SCALE * ((1 << SAMPLE_W) - 1) + 1);
   localparam int KEY_BANDS     = 11;
   localparam int BAND_FIRST_LO = 5;
   localparam int BAND_FIRST_HI = 15;
   localparam int BAND_STEP     = 10;
   localparam int CANCEL_LO     = 105;
   localparam int NONE_HI       = 5;

   localparam logic [KEY_W-1:0] KEY_DIGIT0 = 4'd0;
   localparam logic [KEY_W-1:0] KEY_CANCEL = 4'd11;
   localparam logic [KEY_W-1:0] KEY_NONE   = 4'd12;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_ch0;
      logic [SAMPLE_W-1:0] sample_ch1;
      logic [SAMPLE_W-1:0] sample_ch2;
      logic [SAMPLE_W-1:0] sample_ch3;
      logic [SAMPLE_W-1:0] sample_ch4;
      logic [SAMPLE_W-1:0] sample_ch5;
      logic [SAMPLE_W-1:0] sample_ch6;
      logic [SAMPLE_W-1:0] sample_ch7;
   } req_data_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] mean_ch0;
      logic [SAMPLE_W-1:0] mean_ch1;
      logic [SAMPLE_W-1:0] mean_ch2;
      logic [SAMPLE_W-1:0] mean_ch3;
      logic [SAMPLE_W-1:0] mean_ch4;
      logic [SAMPLE_W-1:0] mean_ch5;
      logic [SAMPLE_W-1:0] mean_ch6;
      logic [SAMPLE_W-1:0] mean_ch7;
      logic [KEY_W-1:0]    key_code;
   } rsp_data_type;

   // one channel step from the sequencer into the channel path
   typedef struct packed {
      logic                valid;
      logic [CH_W-1:0]     ch;
      logic [SLOT_W-1:0]   slot;
      logic [SAMPLE_W-1:0] sample;
      logic                old_ok;
      logic                sum_ok;
   } step_type;

   // one channel mean from the channel path into the collector
   typedef struct packed {
      logic                valid;
      logic [CH_W-1:0]     ch;
      logic [SAMPLE_W-1:0] mean;
   } mean_type;

   // open bands give a digit or confirm, at or above the top band's upper edge cancel, below the
   // first none, exactly on any other edge the held code stays
   function automatic logic [KEY_W-1:0] key_decode(input logic [SAMPLE_W-1:0] mean,
                                                   input logic [KEY_W-1:0]    held);
      logic [LADDER_P_W-1:0] p;
      logic [KEY_W-1:0]      key;
      logic                  hit;
      p   = LADDER_P_W'(mean) * LADDER_P_W'(LADDER_SCALE);
      key = held;
      hit = 1'b0;
      for (int k = 0; k < KEY_BANDS; k++) begin
         if (!hit && (p > LADDER_P_W'((BAND_FIRST_LO + BAND_STEP * k) * LADDER_FULL))
                  && (p < LADDER_P_W'((BAND_FIRST_HI + BAND_STEP * k) * LADDER_FULL))) begin
            key = KEY_W'(k);
            hit = 1'b1;
         end
      end
      if (!hit) begin
         priority if (p > LADDER_P_W'(CANCEL_LO * LADDER_FULL)) begin
            key = KEY_CANCEL;
         end else if (p < LADDER_P_W'(NONE_HI * LADDER_FULL)) begin
            key = KEY_NONE;
         end else begin
            key = held;
         end
      end
      return key;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/amlk_seq.sv =====
// frame register and channel sequencer: takes one frame, issues one channel step per cycle
// depends on amlk_pkg
`default_nettype none

module amlk_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire amlk_pkg::req_data_type req_data,
   input  wire logic                  rsp_transfer,
   output amlk_pkg::step_type         step
);
   import amlk_pkg::*;

   localparam logic [1:0] INFLIGHT_MAX = 2'd2;

   logic [SAMPLE_W-1:0] req_samples [NUM_FIELDS];
   logic [SAMPLE_W-1:0] frame_ff [CHANNELS];
   logic [SAMPLE_W-1:0] frame_in [CHANNELS];
   logic                busy_ff, busy_in;
   logic [CH_W-1:0]     ch_ff, ch_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [SLOT_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                old_ok_ff, old_ok_in;
   logic                sum_ok_ff, sum_ok_in;
   logic [1:0]          inflight_ff, inflight_in;
   logic                last_step;
   logic                req_transfer;

   always_comb begin
      req_samples[0] = req_data.sample_ch0;
      req_samples[1] = req_data.sample_ch1;
      req_samples[2] = req_data.sample_ch2;
      req_samples[3] = req_data.sample_ch3;
      req_samples[4] = req_data.sample_ch4;
      req_samples[5] = req_data.sample_ch5;
      req_samples[6] = req_data.sample_ch6;
      req_samples[7] = req_data.sample_ch7;
   end

   assign last_step    = busy_ff && (ch_ff == CH_W'(CHANNELS - 1));
   // at most two frames between acceptance and delivery: one assembling, one in the output
   assign req_stall    = !((!busy_ff || last_step) && (inflight_ff < INFLIGHT_MAX));
   assign req_transfer = req_valid && !req_stall;

   always_comb begin
      frame_in    = frame_ff;
      busy_in     = busy_ff;
      ch_in       = ch_ff;
      slot_in     = slot_ff;
      ptr_in      = ptr_ff;
      cnt_in      = cnt_ff;
      old_ok_in   = old_ok_ff;
      sum_ok_in   = sum_ok_ff;
      inflight_in = inflight_ff;
      if (busy_ff) begin
         ch_in = ch_ff + CH_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            ch_in   = '0;
         end
      end
      if (req_transfer) begin
         for (int c = 0; c < CHANNELS; c++) begin
            frame_in[c] = req_samples[c];
         end
         busy_in   = 1'b1;
         ch_in     = '0;
         slot_in   = ptr_ff;
         // window entries count as zero until WINDOW frames have gone by
         old_ok_in = (cnt_ff == CNT_W'(WINDOW));
         sum_ok_in = (cnt_ff != '0);
         ptr_in    = (ptr_ff == SLOT_W'(WINDOW - 1)) ? '0 : ptr_ff + SLOT_W'(1);
         cnt_in    = (cnt_ff == CNT_W'(WINDOW)) ? cnt_ff : cnt_ff + CNT_W'(1);
      end
      unique case ({req_transfer, rsp_transfer})
         2'b10:   inflight_in = inflight_ff + 2'd1;
         2'b01:   inflight_in = inflight_ff - 2'd1;
         default: inflight_in = inflight_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         ch_ff       <= '0;
         ptr_ff      <= '0;
         cnt_ff      <= '0;
         inflight_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         ch_ff       <= ch_in;
         ptr_ff      <= ptr_in;
         cnt_ff      <= cnt_in;
         inflight_ff <= inflight_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff  <= frame_in;
      slot_ff   <= slot_in;
      old_ok_ff <= old_ok_in;
      sum_ok_ff <= sum_ok_in;
   end

   always_comb begin
      step.valid  = busy_ff;
      step.ch     = ch_ff;
      step.slot   = slot_ff;
      step.sample = frame_ff[ch_ff];
      step.old_ok = old_ok_ff;
      step.sum_ok = sum_ok_ff;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/amlk_chan_path.sv =====
// shared channel path: window and running-sum memories, read-modify-write, divide by window
// depends on amlk_pkg
`default_nettype none

module amlk_chan_path (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire amlk_pkg::step_type step,
   output amlk_pkg::mean_type     mean_step
);
   import amlk_pkg::*;

   logic [SAMPLE_W-1:0] win_mem_ff [WIN_DEPTH];
   logic [SUM_W-1:0]    sum_mem_ff [CHANNELS];

   logic [WADDR_W-1:0]  rd_addr;
   logic [SAMPLE_W-1:0] win_rd_ff;
   logic [SUM_W-1:0]    sum_rd_ff;

   // read stage
   logic                s1_valid_ff, s1_valid_in;
   logic [CH_W-1:0]     s1_ch_ff, s1_ch_in;
   logic [WADDR_W-1:0]  s1_addr_ff, s1_addr_in;
   logic [SAMPLE_W-1:0] s1_sample_ff, s1_sample_in;
   logic                s1_old_ok_ff, s1_old_ok_in;
   logic                s1_sum_ok_ff, s1_sum_ok_in;
   logic                s1_fwd_win_ff, s1_fwd_win_in;
   logic                s1_fwd_sum_ff, s1_fwd_sum_in;

   // update stage
   logic                s2_valid_ff, s2_valid_in;
   logic [CH_W-1:0]     s2_ch_ff, s2_ch_in;
   logic [SAMPLE_W-1:0] s2_sample_ff, s2_sample_in;
   logic [SUM_W-1:0]    s2_sum_ff, s2_sum_in;
   logic [SAMPLE_W-1:0] old_val;
   logic [SUM_W-1:0]    sum_val;
   logic [SUM_W:0]      new_sum_wide;

   // divide stage
   logic                m_valid_ff, m_valid_in;
   logic [CH_W-1:0]     m_ch_ff, m_ch_in;
   logic [SAMPLE_W-1:0] m_mean_ff, m_mean_in;
   logic [PROD_W-1:0]   prod;

   assign rd_addr = WADDR_W'(step.ch) * WADDR_W'(WINDOW) + WADDR_W'(step.slot);

   always_comb begin
      s1_valid_in   = step.valid;
      s1_ch_in      = step.ch;
      s1_addr_in    = rd_addr;
      s1_sample_in  = step.sample;
      s1_old_ok_in  = step.old_ok;
      s1_sum_ok_in  = step.sum_ok;
      // entry written back this cycle misses the read: take it from the update stage instead
      s1_fwd_win_in = s1_valid_ff && (s1_addr_ff == rd_addr);
      s1_fwd_sum_in = s1_valid_ff && (s1_ch_ff == step.ch);
   end

   always_comb begin
      old_val = '0;
      if (s1_old_ok_ff) begin
         old_val = s1_fwd_win_ff ? s2_sample_ff : win_rd_ff;
      end
      sum_val = '0;
      if (s1_sum_ok_ff) begin
         sum_val = s1_fwd_sum_ff ? s2_sum_ff : sum_rd_ff;
      end
      new_sum_wide = {1'b0, sum_val} - (SUM_W + 1)'(old_val) + (SUM_W + 1)'(s1_sample_ff);
      s2_valid_in  = s1_valid_ff;
      s2_ch_in     = s1_ch_ff;
      s2_sample_in = s1_sample_ff;
      s2_sum_in    = new_sum_wide[SUM_W-1:0];
   end

   always_comb begin
      prod       = PROD_W'(s2_sum_ff) * PROD_W'(RECIP);
      m_valid_in = s2_valid_ff;
      m_ch_in    = s2_ch_ff;
      m_mean_in  = prod[RECIP_SHIFT +: SAMPLE_W];
   end

   // memories: one read and one write port each
   always_ff @(posedge clock) begin
      win_rd_ff <= win_mem_ff[rd_addr];
      sum_rd_ff <= sum_mem_ff[step.ch];
      if (s1_valid_ff) begin
         win_mem_ff[s1_addr_ff] <= s1_sample_ff;
         sum_mem_ff[s1_ch_ff]   <= s2_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         m_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         m_valid_ff  <= m_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ch_ff      <= s1_ch_in;
      s1_addr_ff    <= s1_addr_in;
      s1_sample_ff  <= s1_sample_in;
      s1_old_ok_ff  <= s1_old_ok_in;
      s1_sum_ok_ff  <= s1_sum_ok_in;
      s1_fwd_win_ff <= s1_fwd_win_in;
      s1_fwd_sum_ff <= s1_fwd_sum_in;
      s2_ch_ff      <= s2_ch_in;
      s2_sample_ff  <= s2_sample_in;
      s2_sum_ff     <= s2_sum_in;
      m_ch_ff       <= m_ch_in;
      m_mean_ff     <= m_mean_in;
   end

   always_comb begin
      mean_step.valid = m_valid_ff;
      mean_step.ch    = m_ch_ff;
      mean_step.mean  = m_mean_ff;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/amlk_collect.sv =====
// result collector: gathers channel means, decodes and holds the key, output register
// depends on amlk_pkg
`default_nettype none

module amlk_collect (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire amlk_pkg::mean_type mean_step,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output amlk_pkg::rsp_data_type rsp_data,
   output logic                   rsp_transfer
);
   import amlk_pkg::*;

   logic [SAMPLE_W-1:0] asm_mean_ff [CHANNELS];
   logic [SAMPLE_W-1:0] asm_mean_in [CHANNELS];
   logic [KEY_W-1:0]    asm_key_ff, asm_key_in;
   logic [KEY_W-1:0]    held_key_ff, held_key_in;
   logic                asm_done_ff, asm_done_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_data_type        rsp_data_ff, rsp_data_in;
   logic [SAMPLE_W-1:0] means8 [NUM_FIELDS];
   logic [KEY_W-1:0]    key_now;
   logic                key_write;
   logic                last_write;
   logic                move;

   assign key_now    = key_decode(mean_step.mean, held_key_ff);
   assign key_write  = mean_step.valid && (mean_step.ch == '0);
   assign last_write = mean_step.valid && (mean_step.ch == CH_W'(CHANNELS - 1));
   assign move       = asm_done_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      for (int c = 0; c < NUM_FIELDS; c++) begin
         means8[c] = '0;
      end
      for (int c = 0; c < CHANNELS; c++) begin
         means8[c] = asm_mean_ff[c];
      end
   end

   always_comb begin
      asm_mean_in = asm_mean_ff;
      asm_key_in  = asm_key_ff;
      held_key_in = held_key_ff;
      if (mean_step.valid) begin
         asm_mean_in[mean_step.ch] = mean_step.mean;
      end
      if (key_write) begin
         held_key_in = key_now;
         asm_key_in  = key_now;
      end
      asm_done_in = last_write ? 1'b1 : (move ? 1'b0 : asm_done_ff);

      rsp_data_in = rsp_data_ff;
      if (move) begin
         rsp_data_in.mean_ch0 = means8[0];
         rsp_data_in.mean_ch1 = means8[1];
         rsp_data_in.mean_ch2 = means8[2];
         rsp_data_in.mean_ch3 = means8[3];
         rsp_data_in.mean_ch4 = means8[4];
         rsp_data_in.mean_ch5 = means8[5];
         rsp_data_in.mean_ch6 = means8[6];
         rsp_data_in.mean_ch7 = means8[7];
         rsp_data_in.key_code = asm_key_ff;
      end
      rsp_valid_in = move || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_key_ff  <= KEY_DIGIT0;
         asm_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_key_ff  <= held_key_in;
         asm_done_ff  <= asm_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      asm_mean_ff <= asm_mean_in;
      asm_key_ff  <= asm_key_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_transfer = rsp_valid_ff && !rsp_stall;

   // a finished frame is never overwritten before it moves to the output
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      mean_step.valid |-> (!asm_done_ff || move))
      else $error("assembly overwritten while a finished frame waits");

   a_done_moves: assert property (@(posedge clock) disable iff (reset)
      (asm_done_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished frame did not reach the output register");

   a_held_key: assert property (@(posedge clock) disable iff (reset)
      !key_write |=> $stable(held_key_ff))
      else $error("held key changed without a channel 0 mean");

   a_key_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.key_code <= KEY_NONE))
      else $error("key code out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/adc_moving_average_ladder_keypad_unit.sv =====
// result path: the frame register, the read, update and divide stages and the assembly
// done flag lead to the output register and rsp_valid when the output is free
// throughput: while under two frames are in flight, a new frame is taken on the last channel
// step of the one before; the single channel path serves one channel per cycle over one port
// of each state memory; reset clears control synchronously, the window reads as zeros
// through a frame fill count, no clearing pass, and the held key starts as digit 0
`default_nettype none

module adc_moving_average_ladder_keypad_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // frame input
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire amlk_pkg::req_data_type req_data,
   // result output
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output amlk_pkg::rsp_data_type     rsp_data
);
   import amlk_pkg::*;

   // sequencer -> channel path: one channel step per cycle
   step_type step;
   // channel path -> collector: one channel mean per cycle, registered through the read, update and divide stages
   mean_type mean_step;
   // collector -> sequencer: result transfer, releases a frame credit
   logic     rsp_transfer;

   // frame register, channel counter, window pointer and fill count, frame credits
   amlk_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_transfer (rsp_transfer),
      .step         (step)
   );

   // read window entry and running sum, subtract oldest, add newest, write back,
   // then multiply by the reciprocal of the window length
   amlk_chan_path u_chan_path (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .mean_step (mean_step)
   );

   // assembly of the eight means, keypad decode on channel 0, output register
   amlk_collect u_collect (
      .clock        (clock),
      .reset        (reset),
      .mean_step    (mean_step),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .rsp_transfer (rsp_transfer)
   );

endmodule

`default_nettype wire

// ===== bench/adc_moving_average_ladder_keypad_unit_test.sv =====
// self-checking bench for the adc moving average keypad unit: directed frames, then random
// level bursts, checked per field against typed-in results or a window-mean, ladder predictor
// depends on amlk_pkg and adc_moving_average_ladder_keypad_unit
`default_nettype none

module adc_moving_average_ladder_keypad_unit_test;
   import amlk_pkg::*;

   localparam int RANDOM_FRAMES = 1800;
   localparam int DRAIN_CYCLES  = 20;          // a bit over the frame latency
   localparam int TIMEOUT_TIME  = 12_000_000;  // several times the slowest legal run
   localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
   localparam int BAND_SPAN     = BAND_STEP * LADDER_FULL;
   localparam int NONE_EDGE     = NONE_HI * LADDER_FULL;
   localparam int CANCEL_EDGE   = (CANCEL_LO + BAND_STEP) * LADDER_FULL;
   localparam int REQ_BITS      = $bits(req_data_type);
   localparam int RSP_BITS      = $bits(rsp_data_type);

   // one row of the directed table; want is used only where known is set
   typedef struct {
      req_data_type frame;
      bit           known;
      rsp_data_type want;
   } frame_row_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_data_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_data_type rsp_data;

   // predictor state: per-channel sample history and the held key code
   logic [SAMPLE_W-1:0] window_hist [CHANNELS][WINDOW];
   logic [KEY_W-1:0]    held_code;

   rsp_data_type  pending_results[$];
   frame_row_type directed_rows[$];
   int            mismatches  = 0;
   bit            quiet_phase = 1'b0;  // when set, neither side idles

   adc_moving_average_ladder_keypad_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // ladder decode: below the first edge no key, at or above the top edge cancel,
   // exactly on a band edge the previous code holds, otherwise the band index
   function automatic logic [KEY_W-1:0] ladder_key(input int mean0,
                                                   input logic [KEY_W-1:0] prev);
      int p;
      p = LADDER_SCALE * mean0;
      if (p < NONE_EDGE) return KEY_NONE;
      if (p >= CANCEL_EDGE) return KEY_CANCEL;
      if ((p - NONE_EDGE) % BAND_SPAN == 0) return prev;
      return KEY_W'((p - NONE_EDGE) / BAND_SPAN);
   endfunction

   // shift one frame into the history and form the truncated means and the key
   function automatic rsp_data_type filter_frame(input req_data_type f);
      logic [REQ_BITS-1:0] s;
      logic [RSP_BITS-1:0] r;
      int                  sum;
      int                  mean0;
      s     = f;
      r     = '0;
      mean0 = 0;
      for (int c = 0; c < NUM_FIELDS; c++) begin
         if (c < CHANNELS) begin
            for (int i = 0; i + 1 < WINDOW; i++) begin
               window_hist[c][i] = window_hist[c][i + 1];
            end
            window_hist[c][WINDOW - 1] = s[(NUM_FIELDS - 1 - c) * SAMPLE_W +: SAMPLE_W];
            sum = 0;
            for (int i = 0; i < WINDOW; i++) begin
               sum += window_hist[c][i];
            end
            r[KEY_W + (NUM_FIELDS - 1 - c) * SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(sum / WINDOW);
            if (c == 0) mean0 = sum / WINDOW;
         end
      end
      held_code       = ladder_key(mean0, held_code);
      r[KEY_W - 1:0] = held_code;
      return rsp_data_type'(r);
   endfunction

   // directed frame: channel 0, the odd channels and the even channels each share a value
   function automatic req_data_type frame_fill(input int ch0, input int odd, input int even);
      logic [REQ_BITS-1:0] s;
      for (int c = 0; c < NUM_FIELDS; c++) begin
         s[(NUM_FIELDS - 1 - c) * SAMPLE_W +: SAMPLE_W] =
            SAMPLE_W'((c == 0) ? ch0 : (c % 2 == 1) ? odd : even);
      end
      return req_data_type'(s);
   endfunction

   // typed-in result: channel 0 mean, one mean shared by all other channels, and the key
   function automatic rsp_data_type want_of(input int m0, input int rest,
                                            input logic [KEY_W-1:0] key);
      logic [RSP_BITS-1:0] r;
      for (int c = 0; c < NUM_FIELDS; c++) begin
         r[KEY_W + (NUM_FIELDS - 1 - c) * SAMPLE_W +: SAMPLE_W] =
            SAMPLE_W'((c == 0) ? m0 : (c < CHANNELS) ? rest : 0);
      end
      r[KEY_W - 1:0] = key;
      return rsp_data_type'(r);
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_phase) return 0;
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void check_field(input string name, input logic [SAMPLE_W-1:0] want,
                                       input logic [SAMPLE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // present one frame after a random gap, hold it until the transfer, then predict
   task automatic send_frame(input req_data_type f, input bit known, input rsp_data_type want);
      int           gap;
      rsp_data_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = f;
      do @(posedge clock); while (req_stall !== 1'b0);
      // the predictor runs on every frame so its state stays in step with the block
      predicted = filter_frame(f);
      pending_results.push_back(known ? want : predicted);
      @(negedge clock);
   endtask

   // result side stall pattern: short free runs broken by stalls of random length
   initial begin : result_stall
      int n;
      rsp_stall = 1'b0;
      forever begin
         repeat ($urandom_range(1, 8)) @(negedge clock);
         n = pick_gap();
         if (n > 0) begin
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   // every result transfer is matched against the oldest pending expectation
   always @(posedge clock) begin : result_check
      logic [RSP_BITS-1:0] want_bits;
      logic [RSP_BITS-1:0] got_bits;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with no frame pending");
            mismatches++;
         end else begin
            want_bits = pending_results.pop_front();
            got_bits  = rsp_data;
            for (int c = 0; c < NUM_FIELDS; c++) begin
               check_field($sformatf("mean_ch%0d", c),
                           want_bits[KEY_W + (NUM_FIELDS - 1 - c) * SAMPLE_W +: SAMPLE_W],
                           got_bits[KEY_W + (NUM_FIELDS - 1 - c) * SAMPLE_W +: SAMPLE_W]);
            end
            check_field("key_code", want_bits[KEY_W - 1:0], got_bits[KEY_W - 1:0]);
         end
      end
   end

   initial begin : stimulus
      logic [REQ_BITS-1:0] fbits;
      int                  burst_left;
      int                  mode;
      int                  level;
      int                  pick;

      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      burst_left = 0;
      mode       = 0;
      level      = 0;
      held_code  = KEY_DIGIT0;
      for (int c = 0; c < CHANNELS; c++) begin
         for (int i = 0; i < WINDOW; i++) window_hist[c][i] = '0;
      end

      // directed table: zero window after reset, full scale, the four means that sit
      // exactly on band edges, no key, cancel, and samples one step either side of 512
      directed_rows.push_back('{frame_fill(0, 0, 0), 1'b1, want_of(0, 0, KEY_NONE)});
      directed_rows.push_back('{frame_fill(4095, 4095, 4095), 1'b0, '0});
      directed_rows.push_back('{frame_fill(4095, 4095, 4095), 1'b0, '0});
      directed_rows.push_back('{frame_fill(4095, 4095, 4095), 1'b1,
                                want_of(4095, 4095, KEY_CANCEL)});
      directed_rows.push_back('{frame_fill(512, 'hAAA, 'h555), 1'b0, '0});
      directed_rows.push_back('{frame_fill(512, 'hAAA, 'h555), 1'b0, '0});
      directed_rows.push_back('{frame_fill(512, 'hAAA, 'h555), 1'b0, '0});
      directed_rows.push_back('{frame_fill(1536, 'h555, 'hAAA), 1'b0, '0});
      directed_rows.push_back('{frame_fill(1536, 'h555, 'hAAA), 1'b0, '0});
      directed_rows.push_back('{frame_fill(1536, 'h555, 'hAAA), 1'b0, '0});
      directed_rows.push_back('{frame_fill(2560, 'hFFF, 'h000), 1'b0, '0});
      directed_rows.push_back('{frame_fill(2560, 'hFFF, 'h000), 1'b0, '0});
      directed_rows.push_back('{frame_fill(2560, 'hFFF, 'h000), 1'b0, '0});
      directed_rows.push_back('{frame_fill(3584, 'h001, 'h800), 1'b0, '0});
      directed_rows.push_back('{frame_fill(3584, 'h001, 'h800), 1'b0, '0});
      directed_rows.push_back('{frame_fill(3584, 'h001, 'h800), 1'b0, '0});
      directed_rows.push_back('{frame_fill(0, 'h7FF, 'hFFE), 1'b0, '0});
      directed_rows.push_back('{frame_fill(0, 'h7FF, 'hFFE), 1'b0, '0});
      directed_rows.push_back('{frame_fill(0, 'h7FF, 'hFFE), 1'b0, '0});
      directed_rows.push_back('{frame_fill(4095, 0, 0), 1'b0, '0});
      directed_rows.push_back('{frame_fill(4095, 0, 0), 1'b0, '0});
      directed_rows.push_back('{frame_fill(4095, 0, 0), 1'b1, want_of(4095, 0, KEY_CANCEL)});
      directed_rows.push_back('{frame_fill(511, 'h123, 'hEDC), 1'b0, '0});
      directed_rows.push_back('{frame_fill(513, 'h800, 'h7FF), 1'b0, '0});
      directed_rows.push_back('{frame_fill(513, 'h800, 'h7FF), 1'b0, '0});

      repeat (6) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         send_frame(directed_rows[i].frame, directed_rows[i].known, directed_rows[i].want);
      end

      // random part: channel 0 is held at a level for a short burst so the window mean
      // settles there; levels favor band edges, band interiors and both ends of the scale
      for (int n = 0; n < RANDOM_FRAMES; n++) begin
         if (n % 150 == 0) quiet_phase = ($urandom_range(0, 3) == 0);
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 6);
            mode       = $urandom_range(0, 99);
            if (mode < 55) begin
               // edge means 512, 1536, 2560, 3584 and one step off either side
               level = 1024 * $urandom_range(1, 4) - 512 + $urandom_range(0, 2) - 1;
            end else if (mode < 75) begin
               level = ((BAND_FIRST_LO + 5 + BAND_STEP * $urandom_range(0, KEY_BANDS - 1))
                        * LADDER_FULL) / LADDER_SCALE;
            end else if (mode < 87) begin
               level = $urandom_range(0, 200);
            end else begin
               level = $urandom_range(3850, SAMPLE_MAX);
            end
         end
         burst_left--;
         // a quarter of the bursts are plain noise on channel 0
         fbits[(NUM_FIELDS - 1) * SAMPLE_W +: SAMPLE_W] =
            SAMPLE_W'((mode < 25) ? $urandom_range(0, SAMPLE_MAX) : level);
         for (int c = 1; c < NUM_FIELDS; c++) begin
            pick = $urandom_range(0, 9);
            fbits[(NUM_FIELDS - 1 - c) * SAMPLE_W +: SAMPLE_W] =
               SAMPLE_W'((pick == 0) ? 0 : (pick == 1) ? SAMPLE_MAX :
                         $urandom_range(0, SAMPLE_MAX));
         end
         send_frame(req_data_type'(fbits), 1'b0, '0);
      end
      req_valid = 1'b0;

      // drain: every expected result in, then a wait for stray transfers
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // hang guard
   initial begin : watchdog
      #(TIMEOUT_TIME);
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
